// ===== src/image_chunk_base64_framer_unit_macros.svh =====
// Assertion helpers used by the framer control module.
`ifndef IMAGE_CHUNK_BASE64_FRAMER_UNIT_MACROS_SVH
`define IMAGE_CHUNK_BASE64_FRAMER_UNIT_MACROS_SVH

// Condition implies consequence in the same cycle.
`define ICBF_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("icbf same-cycle check failed");

// Condition implies consequence in the next cycle.
`define ICBF_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("icbf next-cycle check failed");

`endif

// ===== src/icbf_pkg.sv =====
package icbf_pkg;

   localparam int IDW  = 32;
   localparam int DIMW = 16;
   localparam int CNTW = 34;
   localparam int BCDW = 40;
   localparam int DIGN = 10;

   localparam logic [7:0] CH_ESC  = 8'h1B;
   localparam logic [7:0] CH_BSL  = 8'h5C;
   localparam logic [7:0] CH_EQ   = 8'h3D;
   localparam logic [7:0] CH_SEMI = 8'h3B;
   localparam logic [7:0] CH_ZERO = 8'h30;
   localparam logic [7:0] CH_ONE  = 8'h31;

   // header script codes that are not literal characters
   localparam logic [7:0] CODE_END  = 8'h00;
   localparam logic [7:0] CODE_ID   = 8'h01;
   localparam logic [7:0] CODE_W    = 8'h02;
   localparam logic [7:0] CODE_H    = 8'h03;
   localparam logic [7:0] CODE_MORE = 8'h04;

   localparam logic [5:0] SCRIPT_FIRST = 6'd0;
   localparam logic [5:0] SCRIPT_NEXT  = 6'd33;

   localparam logic [1:0] KIND_LIT = 2'd0;
   localparam logic [1:0] KIND_NUM = 2'd1;
   localparam logic [1:0] KIND_END = 2'd2;

   localparam logic [1:0] REG_ID = 2'd0;
   localparam logic [1:0] REG_W  = 2'd1;
   localparam logic [1:0] REG_H  = 2'd2;

   typedef struct packed {
      logic take;
      logic plan;
      logic hdr_lit;
      logic conv_load;
      logic conv_step;
      logic dig_begin;
      logic dig_emit;
      logic grp_shift;
      logic grp_emit;
      logic pad_emit;
      logic term_emit;
      logic finish;
   } cmd_type;

   typedef struct packed {
      logic       emit_ok;
      logic       zero_size;
      logic       hdr_needed;
      logic [1:0] kind;
      logic       conv_done;
      logic       dig_last;
      logic       grp_full;
      logic       end_needed;
      logic       pad_needed;
      logic       sub_last3;
      logic       sub_last1;
   } status_type;

   function automatic logic [7:0] script_char(input logic [5:0] p);
      logic [7:0] c;
      unique case (p)
         6'd0:  c = CH_ESC;
         6'd1:  c = "_";
         6'd2:  c = "G";
         6'd3:  c = "a";
         6'd4:  c = "=";
         6'd5:  c = "T";
         6'd6:  c = ",";
         6'd7:  c = "f";
         6'd8:  c = "=";
         6'd9:  c = "3";
         6'd10: c = "2";
         6'd11: c = ",";
         6'd12: c = "i";
         6'd13: c = "=";
         6'd14: c = CODE_ID;
         6'd15: c = ",";
         6'd16: c = "q";
         6'd17: c = "=";
         6'd18: c = "2";
         6'd19: c = ",";
         6'd20: c = "s";
         6'd21: c = "=";
         6'd22: c = CODE_W;
         6'd23: c = ",";
         6'd24: c = "v";
         6'd25: c = "=";
         6'd26: c = CODE_H;
         6'd27: c = ",";
         6'd28: c = "m";
         6'd29: c = "=";
         6'd30: c = CODE_MORE;
         6'd31: c = CH_SEMI;
         6'd32: c = CODE_END;
         6'd33: c = CH_ESC;
         6'd34: c = "_";
         6'd35: c = "G";
         6'd36: c = "i";
         6'd37: c = "=";
         6'd38: c = CODE_ID;
         6'd39: c = ",";
         6'd40: c = "q";
         6'd41: c = "=";
         6'd42: c = "2";
         6'd43: c = ",";
         6'd44: c = "m";
         6'd45: c = "=";
         6'd46: c = CODE_MORE;
         6'd47: c = CH_SEMI;
         default: c = CODE_END;
      endcase
      return c;
   endfunction

   function automatic logic [7:0] b64_char(input logic [5:0] v);
      logic [7:0] c;
      if (v < 6'd26) begin
         c = 8'h41 + {2'b00, v};
      end else if (v < 6'd52) begin
         c = 8'h61 + {2'b00, v} - 8'd26;
      end else if (v < 6'd62) begin
         c = 8'h30 + {2'b00, v} - 8'd52;
      end else if (v == 6'd62) begin
         c = "+";
      end else begin
         c = "/";
      end
      return c;
   endfunction

   function automatic logic [5:0] b64_pick(input logic [23:0] v, input logic [1:0] k);
      logic [5:0] s;
      unique case (k)
         2'd0: s = v[23:18];
         2'd1: s = v[17:12];
         2'd2: s = v[11:6];
         2'd3: s = v[5:0];
      endcase
      return s;
   endfunction

endpackage

// ===== src/icbf_req_if.sv =====
interface icbf_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] pixel_byte;
   modport source (output valid, output pixel_byte, input ready);
   modport sink (input valid, input pixel_byte, output ready);
endinterface

// ===== src/icbf_rsp_if.sv =====
interface icbf_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_char;
   logic       run_last;
   logic       chunk_end;
   logic       image_end;
   modport source (output valid, output out_char, output run_last, output chunk_end,
                   output image_end, input ready);
   modport sink (input valid, input out_char, input run_last, input chunk_end,
                 input image_end, output ready);
endinterface

// ===== src/image_chunk_base64_framer_unit.sv =====
// One byte per word in, one character per word out; a byte is accepted only in idle.
// A byte that completes no group is only buffered; a completed group emits 4 characters.
// A chunk header emits its script characters and each decimal number from a
// 32-step binary-to-BCD conversion; a chunk close adds up to 6 output characters.
// Synchronous active-high reset: counters cleared, image_id 1, size 0, output empty.
module image_chunk_base64_framer_unit #(
   parameter int CHUNK_BYTES = 3072
) (
   input  logic        clock,
   input  logic        reset,
   icbf_req_if.sink    req_chan,
   icbf_rsp_if.source  rsp_chan,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [3:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);
   import icbf_pkg::*;

   cmd_type     cmd;
   status_type  st;
   logic [31:0] image_id;
   logic [15:0] image_width;
   logic [15:0] image_height;
   logic [33:0] total_bytes;
   logic        zero_size;

   icbf_csr u_csr (
      .clock        (clock),
      .reset        (reset),
      .psel         (psel),
      .penable      (penable),
      .pwrite       (pwrite),
      .paddr        (paddr),
      .pwdata       (pwdata),
      .prdata       (prdata),
      .pready       (pready),
      .image_id     (image_id),
      .image_width  (image_width),
      .image_height (image_height),
      .total_bytes  (total_bytes),
      .zero_size    (zero_size)
   );

   icbf_dp #(.CHUNK_BYTES(CHUNK_BYTES)) u_dp (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .st           (st),
      .pixel_byte   (req_chan.pixel_byte),
      .image_id     (image_id),
      .image_width  (image_width),
      .image_height (image_height),
      .total_bytes  (total_bytes),
      .zero_size    (zero_size),
      .rsp_valid    (rsp_chan.valid),
      .rsp_ready    (rsp_chan.ready),
      .out_char     (rsp_chan.out_char),
      .run_last     (rsp_chan.run_last),
      .chunk_end    (rsp_chan.chunk_end),
      .image_end    (rsp_chan.image_end)
   );

   icbf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .st        (st),
      .cmd       (cmd)
   );

endmodule

// ===== src/icbf_csr.sv =====
module icbf_csr (
   input  logic        clock,
   input  logic        reset,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [3:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready,
   output logic [31:0] image_id,
   output logic [15:0] image_width,
   output logic [15:0] image_height,
   output logic [33:0] total_bytes,
   output logic        zero_size
);
   import icbf_pkg::*;

   logic [IDW-1:0]  id_ff, id_in;
   logic [DIMW-1:0] width_ff, width_in;
   logic [DIMW-1:0] height_ff, height_in;
   logic [31:0]     prod_ff, prod_in;
   logic            wr;

   assign wr = psel && penable && pwrite;

   always_comb begin
      id_in     = id_ff;
      width_in  = width_ff;
      height_in = height_ff;
      if (wr) begin
         priority case (paddr[3:2])
            REG_ID: id_in     = pwdata;
            REG_W:  width_in  = pwdata[DIMW-1:0];
            REG_H:  height_in = pwdata[DIMW-1:0];
            default: ;
         endcase
      end
      prod_in = width_ff * height_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         id_ff     <= 32'd1;
         width_ff  <= '0;
         height_ff <= '0;
         prod_ff   <= '0;
      end else begin
         id_ff     <= id_in;
         width_ff  <= width_in;
         height_ff <= height_in;
         prod_ff   <= prod_in;
      end
   end

   always_comb begin
      priority case (paddr[3:2])
         REG_ID:  prdata = id_ff;
         REG_W:   prdata = {16'd0, width_ff};
         REG_H:   prdata = {16'd0, height_ff};
         default: prdata = '0;
      endcase
   end

   assign pready       = 1'b1;
   assign image_id     = id_ff;
   assign image_width  = width_ff;
   assign image_height = height_ff;
   assign total_bytes  = {prod_ff, 2'b00};
   assign zero_size    = (width_ff == '0) || (height_ff == '0);

endmodule

// ===== src/icbf_dp.sv =====
module icbf_dp #(
   parameter int CHUNK_BYTES = 3072
) (
   input  logic              clock,
   input  logic              reset,
   input  icbf_pkg::cmd_type cmd,
   output icbf_pkg::status_type st,
   input  logic [7:0]        pixel_byte,
   input  logic [31:0]       image_id,
   input  logic [15:0]       image_width,
   input  logic [15:0]       image_height,
   input  logic [33:0]       total_bytes,
   input  logic              zero_size,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [7:0]        out_char,
   output logic              run_last,
   output logic              chunk_end,
   output logic              image_end
);
   import icbf_pkg::*;

   localparam int CPW = (CHUNK_BYTES > 2) ? $clog2(CHUNK_BYTES) : 1;

   logic [7:0]      byte_ff, byte_in;
   logic [CNTW-1:0] bt_ff, bt_in;
   logic [CPW-1:0]  cpos_ff, cpos_in;
   logic [15:0]     gb_ff, gb_in;
   logic [1:0]      fill_ff, fill_in;
   logic            first_ff, first_in;
   logic            last_ff, last_in;
   logic            more_ff, more_in;
   logic            wend_ff, wend_in;
   logic            wgrp_ff, wgrp_in;
   logic            hdr_ff, hdr_in;
   logic [5:0]      sp_ff, sp_in;
   logic [31:0]     cv_ff, cv_in;
   logic [BCDW-1:0] bcd_ff, bcd_in;
   logic [4:0]      ccnt_ff, ccnt_in;
   logic [3:0]      di_ff, di_in;
   logic [1:0]      sub_ff, sub_in;
   logic            ov_ff, ov_in;
   logic [7:0]      oc_ff, oc_in;
   logic            orl_ff, orl_in;
   logic            oce_ff, oce_in;
   logic            oie_ff, oie_in;

   logic [7:0]      code;
   logic [BCDW-1:0] bcd_adj;
   logic [3:0]      top_dig;
   logic [23:0]     gv;
   logic [23:0]     pv;
   logic            emit_ok;
   logic            emit;
   logic [34:0]     bt_next;
   logic [34:0]     bt_more;

   assign code    = script_char(sp_ff);
   assign gv      = {gb_ff, byte_ff};
   assign pv      = (fill_ff == 2'd1) ? {gb_ff[7:0], 16'd0} : {gb_ff, 8'd0};
   assign emit_ok = !ov_ff || rsp_ready;
   assign emit    = cmd.hdr_lit || cmd.dig_emit || cmd.grp_emit || cmd.pad_emit ||
                    cmd.term_emit;
   assign bt_next = {1'b0, bt_ff} + 35'd1;
   assign bt_more = {1'b0, bt_ff} + 35'(CHUNK_BYTES);

   always_comb begin
      for (int i = 0; i < DIGN; i++) begin
         bcd_adj[4*i +: 4] = (bcd_ff[4*i +: 4] >= 4'd5) ? bcd_ff[4*i +: 4] + 4'd3
                                                         : bcd_ff[4*i +: 4];
      end
      top_dig = '0;
      for (int i = 0; i < DIGN; i++) begin
         if (bcd_ff[4*i +: 4] != 4'd0) top_dig = 4'(i);
      end
   end

   always_comb begin
      byte_in  = byte_ff;
      bt_in    = bt_ff;
      cpos_in  = cpos_ff;
      gb_in    = gb_ff;
      fill_in  = fill_ff;
      first_in = first_ff;
      last_in  = last_ff;
      more_in  = more_ff;
      wend_in  = wend_ff;
      wgrp_in  = wgrp_ff;
      hdr_in   = hdr_ff;
      sp_in    = sp_ff;
      cv_in    = cv_ff;
      bcd_in   = bcd_ff;
      ccnt_in  = ccnt_ff;
      di_in    = di_ff;
      sub_in   = sub_ff;
      ov_in    = ov_ff && !rsp_ready;
      oc_in    = oc_ff;
      orl_in   = orl_ff;
      oce_in   = oce_ff;
      oie_in   = oie_ff;

      if (cmd.take) byte_in = pixel_byte;

      if (cmd.plan) begin
         last_in = bt_next >= {1'b0, total_bytes};
         more_in = bt_more < {1'b0, total_bytes};
         wend_in = (cpos_ff == CPW'(CHUNK_BYTES - 1)) || (bt_next >= {1'b0, total_bytes});
         wgrp_in = fill_ff == 2'd2;
         hdr_in  = cpos_ff == '0;
         sp_in   = first_ff ? SCRIPT_NEXT : SCRIPT_FIRST;
      end

      if (cmd.hdr_lit) begin
         sp_in = sp_ff + 6'd1;
      end

      if (cmd.conv_load) begin
         priority case (code)
            CODE_ID: cv_in = image_id;
            CODE_W:  cv_in = {16'd0, image_width};
            default: cv_in = {16'd0, image_height};
         endcase
         bcd_in  = '0;
         ccnt_in = '0;
      end

      if (cmd.conv_step) begin
         bcd_in  = {bcd_adj[BCDW-2:0], cv_ff[31]};
         cv_in   = {cv_ff[30:0], 1'b0};
         ccnt_in = ccnt_ff + 5'd1;
      end

      if (cmd.dig_begin) di_in = top_dig;

      if (cmd.dig_emit) begin
         if (di_ff == 4'd0) begin
            sp_in = sp_ff + 6'd1;
         end else begin
            di_in = di_ff - 4'd1;
         end
      end

      if (cmd.grp_shift) begin
         gb_in   = {gb_ff[7:0], byte_ff};
         fill_in = fill_ff + 2'd1;
      end

      if (cmd.grp_emit || cmd.pad_emit) begin
         sub_in = sub_ff + 2'd1;
         if (cmd.grp_emit && sub_ff == 2'd3) begin
            gb_in   = '0;
            fill_in = '0;
         end
      end

      if (cmd.term_emit) begin
         sub_in = (sub_ff == 2'd1) ? 2'd0 : sub_ff + 2'd1;
      end

      if (cmd.finish) begin
         bt_in    = last_ff ? '0 : bt_ff + 34'd1;
         cpos_in  = wend_ff ? '0 : cpos_ff + CPW'(1);
         first_in = !last_ff && (first_ff || hdr_ff);
         sub_in   = '0;
         if (wend_ff) begin
            gb_in   = '0;
            fill_in = '0;
         end
      end

      if (emit) begin
         ov_in  = 1'b1;
         orl_in = 1'b0;
         oce_in = 1'b0;
         oie_in = 1'b0;
         priority if (cmd.hdr_lit) begin
            oc_in  = (code == CODE_MORE) ? (more_ff ? CH_ONE : CH_ZERO) : code;
            orl_in = (code == CH_SEMI) && !wgrp_ff && !wend_ff;
         end else if (cmd.dig_emit) begin
            oc_in = CH_ZERO + {4'd0, bcd_ff[4*di_ff +: 4]};
         end else if (cmd.grp_emit) begin
            oc_in  = b64_char(b64_pick(gv, sub_ff));
            orl_in = (sub_ff == 2'd3) && !wend_ff;
         end else if (cmd.pad_emit) begin
            oc_in = (sub_ff <= fill_ff) ? b64_char(b64_pick(pv, sub_ff)) : CH_EQ;
         end else begin
            oc_in = (sub_ff == 2'd0) ? CH_ESC : CH_BSL;
            if (sub_ff == 2'd1) begin
               orl_in = 1'b1;
               oce_in = 1'b1;
               oie_in = last_ff;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bt_ff    <= '0;
         cpos_ff  <= '0;
         gb_ff    <= '0;
         fill_ff  <= '0;
         first_ff <= 1'b0;
         sp_ff    <= '0;
         ccnt_ff  <= '0;
         di_ff    <= '0;
         sub_ff   <= '0;
         ov_ff    <= 1'b0;
      end else begin
         bt_ff    <= bt_in;
         cpos_ff  <= cpos_in;
         gb_ff    <= gb_in;
         fill_ff  <= fill_in;
         first_ff <= first_in;
         sp_ff    <= sp_in;
         ccnt_ff  <= ccnt_in;
         di_ff    <= di_in;
         sub_ff   <= sub_in;
         ov_ff    <= ov_in;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff <= byte_in;
      last_ff <= last_in;
      more_ff <= more_in;
      wend_ff <= wend_in;
      wgrp_ff <= wgrp_in;
      hdr_ff  <= hdr_in;
      cv_ff   <= cv_in;
      bcd_ff  <= bcd_in;
      oc_ff   <= oc_in;
      orl_ff  <= orl_in;
      oce_ff  <= oce_in;
      oie_ff  <= oie_in;
   end

   always_comb begin
      st.emit_ok    = emit_ok;
      st.zero_size  = zero_size;
      st.hdr_needed = cpos_ff == '0;
      if (code == CODE_END) begin
         st.kind = KIND_END;
      end else if (code == CODE_ID || code == CODE_W || code == CODE_H) begin
         st.kind = KIND_NUM;
      end else begin
         st.kind = KIND_LIT;
      end
      st.conv_done  = ccnt_ff == 5'd31;
      st.dig_last   = di_ff == 4'd0;
      st.grp_full   = fill_ff == 2'd2;
      st.end_needed = wend_ff;
      st.pad_needed = fill_ff != 2'd0;
      st.sub_last3  = sub_ff == 2'd3;
      st.sub_last1  = sub_ff == 2'd1;
   end

   assign rsp_valid = ov_ff;
   assign out_char  = oc_ff;
   assign run_last  = orl_ff;
   assign chunk_end = oce_ff;
   assign image_end = oie_ff;

endmodule

// ===== src/icbf_ctrl.sv =====
`include "image_chunk_base64_framer_unit_macros.svh"

module icbf_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  icbf_pkg::status_type st,
   output icbf_pkg::cmd_type    cmd
);
   import icbf_pkg::*;

   localparam logic [3:0] S_IDLE = 4'd0;
   localparam logic [3:0] S_PLAN = 4'd1;
   localparam logic [3:0] S_HDR  = 4'd2;
   localparam logic [3:0] S_CONV = 4'd3;
   localparam logic [3:0] S_DSET = 4'd4;
   localparam logic [3:0] S_DIG  = 4'd5;
   localparam logic [3:0] S_GRP  = 4'd6;
   localparam logic [3:0] S_ECHK = 4'd7;
   localparam logic [3:0] S_PAD  = 4'd8;
   localparam logic [3:0] S_TERM = 4'd9;
   localparam logic [3:0] S_FIN  = 4'd10;

   logic [3:0] state_ff, state_in;

   assign req_ready = state_ff == S_IDLE;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.take = 1'b1;
               if (!st.zero_size) state_in = S_PLAN;
            end
         end
         S_PLAN: begin
            cmd.plan = 1'b1;
            state_in = st.hdr_needed ? S_HDR : S_GRP;
         end
         S_HDR: begin
            priority if (st.kind == KIND_END) begin
               state_in = S_GRP;
            end else if (st.kind == KIND_NUM) begin
               cmd.conv_load = 1'b1;
               state_in      = S_CONV;
            end else if (st.emit_ok) begin
               cmd.hdr_lit = 1'b1;
            end
         end
         S_CONV: begin
            cmd.conv_step = 1'b1;
            if (st.conv_done) state_in = S_DSET;
         end
         S_DSET: begin
            cmd.dig_begin = 1'b1;
            state_in      = S_DIG;
         end
         S_DIG: begin
            if (st.emit_ok) begin
               cmd.dig_emit = 1'b1;
               if (st.dig_last) state_in = S_HDR;
            end
         end
         S_GRP: begin
            if (st.grp_full) begin
               if (st.emit_ok) begin
                  cmd.grp_emit = 1'b1;
                  if (st.sub_last3) state_in = S_ECHK;
               end
            end else begin
               cmd.grp_shift = 1'b1;
               state_in      = S_ECHK;
            end
         end
         S_ECHK: begin
            if (!st.end_needed) begin
               state_in = S_FIN;
            end else begin
               state_in = st.pad_needed ? S_PAD : S_TERM;
            end
         end
         S_PAD: begin
            if (st.emit_ok) begin
               cmd.pad_emit = 1'b1;
               if (st.sub_last3) state_in = S_TERM;
            end
         end
         S_TERM: begin
            if (st.emit_ok) begin
               cmd.term_emit = 1'b1;
               if (st.sub_last1) state_in = S_FIN;
            end
         end
         S_FIN: begin
            cmd.finish = 1'b1;
            state_in   = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   `ICBF_ASSERT_IMP(a_emit_room, clock, reset, (cmd.hdr_lit || cmd.dig_emit || cmd.grp_emit || cmd.pad_emit || cmd.term_emit), st.emit_ok)
   `ICBF_ASSERT_NXT(a_fin_idle, clock, reset, (state_ff == S_FIN), (state_ff == S_IDLE))
   `ICBF_ASSERT_NXT(a_conv_dset, clock, reset, (state_ff == S_CONV && st.conv_done), (state_ff == S_DSET))
   `ICBF_ASSERT_NXT(a_zero_hold, clock, reset, (state_ff == S_IDLE && req_valid && st.zero_size), (state_ff == S_IDLE))

endmodule
